/* rtl/rvd_pkg.sv */
// Package for the RV32 subset instruction decoder: major opcodes, the dense
// operation numbering, the funct7 classes and the stage payload types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rvd_pkg;

    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_JAL    = 7'h6F;

    localparam logic [6:0] F7_SUB_SRA = 7'h20;
    localparam logic [6:0] F7_MULDIV  = 7'h01;
    localparam logic [6:0] F7_ZERO    = 7'h00;

    localparam int IMM_W  = 21;
    localparam int REG_W  = 5;
    localparam int WORD_W = 32;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,  OP_MUL   = 5'd1,  OP_SUB   = 5'd2,  OP_SLL   = 5'd3,
        OP_MULH  = 5'd4,  OP_SLT   = 5'd5,  OP_XOR   = 5'd6,  OP_DIV   = 5'd7,
        OP_SRL   = 5'd8,  OP_SRA   = 5'd9,  OP_OR    = 5'd10, OP_REM   = 5'd11,
        OP_AND   = 5'd12, OP_ADDI  = 5'd13, OP_SLLI  = 5'd14, OP_SLTI  = 5'd15,
        OP_XORI  = 5'd16, OP_SRLI  = 5'd17, OP_SRAI  = 5'd18, OP_ORI   = 5'd19,
        OP_ANDI  = 5'd20, OP_LB    = 5'd21, OP_LH    = 5'd22, OP_LW    = 5'd23,
        OP_SB    = 5'd24, OP_SH    = 5'd25, OP_SW    = 5'd26, OP_BEQ   = 5'd27,
        OP_BNE   = 5'd28, OP_LUI   = 5'd29, OP_JAL   = 5'd30, OP_ECALL = 5'd31
    } op_t;

    typedef enum logic [1:0] {
        F7C_BASE   = 2'd0,
        F7C_MULDIV = 2'd1,
        F7C_ALT    = 2'd2,
        F7C_NONE   = 2'd3
    } f7c_t;

    typedef struct packed {
        logic is_r;
        logic is_i;
        logic is_load;
        logic is_store;
        logic is_br;
        logic is_lui;
        logic is_jal;
        logic is_sys;
    } cls_t;

    typedef struct packed {
        logic              bad;
        op_t               op;
        logic [REG_W-1:0]  rd;
        logic [REG_W-1:0]  rs1;
        logic [REG_W-1:0]  rs2;
        logic [IMM_W-1:0]  imm;
    } dec_t;

endpackage

`default_nettype wire

/* rtl/rv32_subset_instruction_decoder_top.sv */
// Top level of the RV32 subset instruction decoder: three-stage decode pipeline
// with per-stage valid bits and stream handshakes on both sides.
// Depends on rvd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Decodes one 32-bit RV32I/M-subset instruction per beat into a dense operation
// number, rd/rs1/rs2 and an immediate (sign-extended except for LUI and shifts);
// encodings outside the subset come out with the illegal flag set and every other
// field zero. Throughput is one instruction per clock while the output side does
// not stall; a beat passes opcode classing, field decode and the output register
// in turn. Each stage holds its beat while the next is full and stalled, so
// bubbles close up and a stall on the output side loses nothing.

module rv32_subset_instruction_decoder_top
    import rvd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] instruction_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [4:0] op_code, [9:5] dest_reg,
                                        // [14:10] src1_reg, [19:15] src2_reg,
                                        // [40:20] immediate, [47:41] zero
    output logic [0:0]       m_tuser    // [0] illegal
);

    logic en1, en2, en3;

    logic              v1_reg, v2_reg, v3_reg;
    logic [WORD_W-1:0] w1_reg;
    cls_t              cls1_reg, cls1_next;
    f7c_t              f7c1_reg, f7c1_next;
    dec_t              dec2_reg, dec2_next;
    dec_t              out3_reg, out3_next;

    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // stage 1: major opcode and funct7 class
    always_comb begin
        cls1_next = '0;
        unique case (s_tdata[6:0])
            OPC_OP:     cls1_next.is_r     = 1'b1;
            OPC_OPIMM:  cls1_next.is_i     = 1'b1;
            OPC_LOAD:   cls1_next.is_load  = 1'b1;
            OPC_STORE:  cls1_next.is_store = 1'b1;
            OPC_BRANCH: cls1_next.is_br    = 1'b1;
            OPC_LUI:    cls1_next.is_lui   = 1'b1;
            OPC_JAL:    cls1_next.is_jal   = 1'b1;
            OPC_SYSTEM: cls1_next.is_sys   = 1'b1;
            default:    cls1_next          = '0;
        endcase
        unique case (s_tdata[31:25])
            F7_ZERO:    f7c1_next = F7C_BASE;
            F7_MULDIV:  f7c1_next = F7C_MULDIV;
            F7_SUB_SRA: f7c1_next = F7C_ALT;
            default:    f7c1_next = F7C_NONE;
        endcase
    end

    // stage 2: legality, operation and immediate
    logic [2:0]       f3;
    logic [6:0]       hi;
    logic [REG_W-1:0] rd, rs1, rs2;
    logic [IMM_W-1:0] imm_i, imm_s, imm_b, imm_j, imm_u, imm_sh;

    assign f3     = w1_reg[14:12];
    assign hi     = w1_reg[31:25];
    assign rd     = w1_reg[11:7];
    assign rs1    = w1_reg[19:15];
    assign rs2    = w1_reg[24:20];
    assign imm_i  = {{9{w1_reg[31]}}, w1_reg[31:20]};
    assign imm_s  = {{9{w1_reg[31]}}, w1_reg[31:25], w1_reg[11:7]};
    assign imm_b  = {{8{w1_reg[31]}}, w1_reg[31], w1_reg[7], w1_reg[30:25],
                     w1_reg[11:8], 1'b0};
    assign imm_j  = {w1_reg[31], w1_reg[19:12], w1_reg[20], w1_reg[30:21], 1'b0};
    assign imm_u  = {1'b0, w1_reg[31:12]};
    assign imm_sh = {{(IMM_W-5){1'b0}}, w1_reg[24:20]};

    always_comb begin
        dec2_next     = '0;
        dec2_next.op  = OP_ADD;
        dec2_next.bad = 1'b0;
        if (cls1_reg.is_r) begin
            dec2_next.rd  = rd;
            dec2_next.rs1 = rs1;
            dec2_next.rs2 = rs2;
            unique case ({f3, f7c1_reg})
                {3'd0, F7C_BASE}:   dec2_next.op = OP_ADD;
                {3'd0, F7C_MULDIV}: dec2_next.op = OP_MUL;
                {3'd0, F7C_ALT}:    dec2_next.op = OP_SUB;
                {3'd1, F7C_BASE}:   dec2_next.op = OP_SLL;
                {3'd1, F7C_MULDIV}: dec2_next.op = OP_MULH;
                {3'd2, F7C_BASE}:   dec2_next.op = OP_SLT;
                {3'd4, F7C_BASE}:   dec2_next.op = OP_XOR;
                {3'd4, F7C_MULDIV}: dec2_next.op = OP_DIV;
                {3'd5, F7C_BASE}:   dec2_next.op = OP_SRL;
                {3'd5, F7C_ALT}:    dec2_next.op = OP_SRA;
                {3'd6, F7C_BASE}:   dec2_next.op = OP_OR;
                {3'd6, F7C_MULDIV}: dec2_next.op = OP_REM;
                {3'd7, F7C_BASE}:   dec2_next.op = OP_AND;
                default:            dec2_next.bad = 1'b1;
            endcase
        end else if (cls1_reg.is_i) begin
            dec2_next.rd  = rd;
            dec2_next.rs1 = rs1;
            dec2_next.imm = imm_i;
            unique case (f3)
                3'd0: dec2_next.op = OP_ADDI;
                3'd1: begin
                    dec2_next.op  = OP_SLLI;
                    dec2_next.imm = imm_sh;
                    dec2_next.bad = (hi != F7_ZERO);
                end
                3'd2: dec2_next.op = OP_SLTI;
                3'd4: dec2_next.op = OP_XORI;
                3'd5: begin
                    dec2_next.imm = imm_sh;
                    dec2_next.op  = (hi == F7_SUB_SRA) ? OP_SRAI : OP_SRLI;
                    dec2_next.bad = (hi != F7_ZERO) && (hi != F7_SUB_SRA);
                end
                3'd6: dec2_next.op = OP_ORI;
                3'd7: dec2_next.op = OP_ANDI;
                default: dec2_next.bad = 1'b1;
            endcase
        end else if (cls1_reg.is_load) begin
            dec2_next.rd  = rd;
            dec2_next.rs1 = rs1;
            dec2_next.imm = imm_i;
            dec2_next.op  = op_t'(OP_LB + {2'b00, f3});
            dec2_next.bad = (f3 > 3'd2);
        end else if (cls1_reg.is_store) begin
            dec2_next.rs1 = rs1;
            dec2_next.rs2 = rs2;
            dec2_next.imm = imm_s;
            dec2_next.op  = op_t'(OP_SB + {2'b00, f3});
            dec2_next.bad = (f3 > 3'd2);
        end else if (cls1_reg.is_br) begin
            dec2_next.rs1 = rs1;
            dec2_next.rs2 = rs2;
            dec2_next.imm = imm_b;
            dec2_next.op  = (f3[0]) ? OP_BNE : OP_BEQ;
            dec2_next.bad = (f3 > 3'd1);
        end else if (cls1_reg.is_lui) begin
            dec2_next.rd  = rd;
            dec2_next.imm = imm_u;
            dec2_next.op  = OP_LUI;
        end else if (cls1_reg.is_jal) begin
            dec2_next.rd  = rd;
            dec2_next.imm = imm_j;
            dec2_next.op  = OP_JAL;
        end else if (cls1_reg.is_sys) begin
            dec2_next.op  = OP_ECALL;
            dec2_next.bad = (f3 != 3'd0) || (w1_reg[31:20] != 12'd0);
        end else begin
            dec2_next.bad = 1'b1;
        end
    end

    // stage 3: illegal encodings leave every field zero
    always_comb begin
        out3_next = '0;
        out3_next.op = OP_ADD;
        if (dec2_reg.bad) begin
            out3_next.bad = 1'b1;
        end else begin
            out3_next = dec2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && s_tvalid) begin
            w1_reg   <= s_tdata;
            cls1_reg <= cls1_next;
            f7c1_reg <= f7c1_next;
        end
        if (en2 && v1_reg) dec2_reg <= dec2_next;
        if (en3 && v2_reg) out3_reg <= out3_next;
    end

    assign m_tvalid = v3_reg;
    assign m_tuser  = out3_reg.bad;
    assign m_tdata  = {7'd0, out3_reg.imm, out3_reg.rs2, out3_reg.rs1,
                       out3_reg.rd, out3_reg.op};

    // assertions
    a_illegal_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[40:0] == 41'd0)
        else $error("illegal beat carries nonzero fields");

    a_lui_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] && m_tdata[4:0] == OP_LUI |-> !m_tdata[40])
        else $error("lui immediate has sign bit set");

    a_ecall_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] && m_tdata[4:0] == OP_ECALL
        |-> m_tdata[40:5] == 36'd0)
        else $error("ecall beat carries register or immediate");

    a_stage2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !en3 |=> v2_reg && $stable(dec2_reg))
        else $error("decode stage lost its beat during a stall");

endmodule

`default_nettype wire
